// ===== design/tiny_cpu_execute_unit_defines.svh =====
// Assertion macros used by the execute unit.
`ifndef TINY_CPU_EXECUTE_UNIT_DEFINES_SVH
`define TINY_CPU_EXECUTE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tce_pkg.sv =====
package tce_pkg;

   localparam int NUM_REGS   = 8;
   localparam int REG_IDX_W  = 3;
   localparam int DATA_W     = 8;
   localparam int INSTR_W    = 20;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_ADDI   = 3'd1,
      OP_MUL    = 3'd2,
      OP_INV    = 3'd3,
      OP_BRANCH = 3'd4,
      OP_LOAD   = 3'd5,
      OP_STORE  = 3'd6,
      OP_HALT   = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_req_type;

   localparam logic FUNC_EXEC = 1'b0;
   localparam logic FUNC_LOAD_DATA = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0]    next_pc;
      logic                 halted;
      logic [1:0]           mem_request;
      logic [DATA_W-1:0]    mem_address;
      logic [DATA_W-1:0]    mem_write_data;
      logic                 reg_write;
      logic [REG_IDX_W-1:0] reg_index;
      logic [DATA_W-1:0]    reg_value;
   } result_type;

endpackage

// ===== design/tce_if.sv =====
interface tce_req_if import tce_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [INSTR_W-1:0]    instruction_word;
   logic [DATA_W-1:0]     load_data;

   modport source (output valid, output func, output instruction_word, output load_data,
                   input ready);
   modport sink (input valid, input func, input instruction_word, input load_data,
                 output ready);
endinterface

interface tce_rsp_if import tce_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DATA_W-1:0]     next_pc;
   logic                  halted;
   logic [1:0]            mem_request;
   logic [DATA_W-1:0]     mem_address;
   logic [DATA_W-1:0]     mem_write_data;
   logic                  reg_write;
   logic [REG_IDX_W-1:0]  reg_index;
   logic [DATA_W-1:0]     reg_value;

   modport source (output valid, output next_pc, output halted, output mem_request,
                   output mem_address, output mem_write_data, output reg_write,
                   output reg_index, output reg_value, input ready);
   modport sink (input valid, input next_pc, input halted, input mem_request,
                 input mem_address, input mem_write_data, input reg_write,
                 input reg_index, input reg_value, output ready);
endinterface

// ===== design/tiny_cpu_execute_unit.sv =====
// Execute stage of a small 8-bit processor. Each request transaction carries either an
// instruction word (func 0) or the byte for a pending load (func 1); each one yields exactly
// one response transaction with the new PC, the halt flag, any memory request and any
// register write. The unit accepts one transaction per clock and has two stages: the first
// reads registers s and t from the synchronous register-file memory, the second executes,
// writes back and loads the output register. A request is captured in the first stage, then
// passes through the second stage into the output register, which drives the response
// transaction; back-to-back dependent instructions run at full rate because the most
// recent write is forwarded around the memory. A stalled receiver holds the response and
// then the second stage, which in turn holds off new requests. A load holds the PC and
// ignores further instructions until its data arrives; after a halt every transaction is
// ignored.
`include "tiny_cpu_execute_unit_defines.svh"

module tiny_cpu_execute_unit import tce_pkg::*; (
   input logic        clock,
   input logic        reset,
   tce_req_if.sink    req_ch,
   tce_rsp_if.source  rsp_ch
);

   // Register file: synchronous memory, two read ports, one write port.
   logic [DATA_W-1:0]    regs_mem [NUM_REGS];
   logic [NUM_REGS-1:0]  regs_vld_ff;

   logic                 s1_valid_ff;
   logic                 s1_func_ff;
   logic [INSTR_W-1:0]   s1_word_ff;
   logic [DATA_W-1:0]    s1_ldata_ff;

   logic [DATA_W-1:0]    rd_s_ff, rd_t_ff;
   logic                 rd_s_vld_ff, rd_t_vld_ff;

   logic                 lw_valid_ff;
   logic [REG_IDX_W-1:0] lw_idx_ff;
   logic [DATA_W-1:0]    lw_val_ff;

   logic [DATA_W-1:0]    pc_ff, pc_in;
   logic                 halt_ff, halt_in;
   logic                 ld_pend_ff, ld_pend_in;
   logic [REG_IDX_W-1:0] ld_dest_ff, ld_dest_in;

   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   result_type           res;

   logic                 req_fire, s1_fire;
   logic [REG_IDX_W-1:0] rd_addr_s, rd_addr_t;

   opcode_type           op;
   logic [REG_IDX_W-1:0] s1_d, s1_s, s1_t;
   logic [DATA_W-1:0]    s1_imm, vs, vt, base_pc;
   logic                 taken;

   assign s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // While stage one stalls it keeps re-reading its own operands.
   assign rd_addr_s = req_fire ? req_ch.instruction_word[13:11] : s1_word_ff[13:11];
   assign rd_addr_t = req_fire ? req_ch.instruction_word[10:8]  : s1_word_ff[10:8];

   always_ff @(posedge clock) begin
      rd_s_ff     <= regs_mem[rd_addr_s];
      rd_t_ff     <= regs_mem[rd_addr_t];
      rd_s_vld_ff <= regs_vld_ff[rd_addr_s];
      rd_t_vld_ff <= regs_vld_ff[rd_addr_t];
      if (s1_fire && res.reg_write) begin
         regs_mem[res.reg_index] <= res.reg_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_vld_ff <= '0;
         lw_valid_ff <= 1'b0;
      end else if (s1_fire && res.reg_write) begin
         regs_vld_ff[res.reg_index] <= 1'b1;
         lw_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && res.reg_write) begin
         lw_idx_ff <= res.reg_index;
         lw_val_ff <= res.reg_value;
      end
      if (req_fire) begin
         s1_func_ff  <= req_ch.func;
         s1_word_ff  <= req_ch.instruction_word;
         s1_ldata_ff <= req_ch.load_data;
      end
      if (s1_fire) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         ld_pend_ff   <= 1'b0;
         ld_dest_ff   <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= pc_in;
            halt_ff      <= halt_in;
            ld_pend_ff   <= ld_pend_in;
            ld_dest_ff   <= ld_dest_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign op     = opcode_type'(s1_word_ff[19:17]);
   assign s1_d   = s1_word_ff[16:14];
   assign s1_s   = s1_word_ff[13:11];
   assign s1_t   = s1_word_ff[10:8];
   assign s1_imm = s1_word_ff[7:0];

   // The last write-back may not be in the memory data yet, so it takes priority.
   always_comb begin
      if (lw_valid_ff && lw_idx_ff == s1_s) begin
         vs = lw_val_ff;
      end else begin
         vs = rd_s_vld_ff ? rd_s_ff : '0;
      end
      if (lw_valid_ff && lw_idx_ff == s1_t) begin
         vt = lw_val_ff;
      end else begin
         vt = rd_t_vld_ff ? rd_t_ff : '0;
      end
   end

   always_comb begin
      if (s1_d == '0) begin
         taken = (vs == vt);
      end else if (s1_d[0]) begin
         taken = (vs != vt);
      end else begin
         taken = (vs < vt);
      end
   end

   always_comb begin
      res        = '0;
      pc_in      = pc_ff;
      halt_in    = halt_ff;
      ld_pend_in = ld_pend_ff;
      ld_dest_in = ld_dest_ff;
      base_pc    = pc_ff;
      if (!halt_ff) begin
         if (s1_func_ff == FUNC_LOAD_DATA) begin
            if (ld_pend_ff) begin
               res.reg_write  = 1'b1;
               res.reg_index  = ld_dest_ff;
               res.reg_value  = s1_ldata_ff;
               ld_pend_in     = 1'b0;
               pc_in          = pc_ff + 1'b1;
            end
         end else if (!ld_pend_ff) begin
            case (op)
               OP_ADD: begin
                  res.reg_write = 1'b1;
                  res.reg_index = s1_d;
                  res.reg_value = vs + vt;
               end
               OP_ADDI: begin
                  res.reg_write = 1'b1;
                  res.reg_index = s1_d;
                  res.reg_value = vs + s1_imm;
               end
               OP_MUL: begin
                  res.reg_write = 1'b1;
                  res.reg_index = s1_d;
                  res.reg_value = {4'b0, vs[3:0]} * {4'b0, vs[7:4]};
               end
               OP_INV: begin
                  res.reg_write = 1'b1;
                  res.reg_index = s1_d;
                  res.reg_value = ~vs;
               end
               OP_BRANCH: begin
                  if (taken) begin
                     base_pc = s1_imm;
                  end
               end
               OP_LOAD: begin
                  res.mem_request = MEM_READ;
                  res.mem_address = vt;
                  ld_pend_in      = 1'b1;
                  ld_dest_in      = s1_d;
               end
               OP_STORE: begin
                  res.mem_request    = MEM_WRITE;
                  res.mem_address    = vt;
                  res.mem_write_data = vs;
               end
               default: begin
                  halt_in = 1'b1;
               end
            endcase
            // Every completed instruction advances the PC, a taken branch included.
            if (op != OP_LOAD) begin
               pc_in = base_pc + 1'b1;
            end
         end
      end
      res.next_pc = pc_in;
      res.halted  = halt_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.next_pc        = rsp_ff.next_pc;
   assign rsp_ch.halted         = rsp_ff.halted;
   assign rsp_ch.mem_request    = rsp_ff.mem_request;
   assign rsp_ch.mem_address    = rsp_ff.mem_address;
   assign rsp_ch.mem_write_data = rsp_ff.mem_write_data;
   assign rsp_ch.reg_write      = rsp_ff.reg_write;
   assign rsp_ch.reg_index      = rsp_ff.reg_index;
   assign rsp_ch.reg_value      = rsp_ff.reg_value;

   `TCE_ASSERT_NOW(a_halt_no_write, clock, reset, s1_fire && halt_ff,
      !res.reg_write && res.mem_request == MEM_NONE && pc_in == pc_ff,
      "Halted unit produced a side effect")
   `TCE_ASSERT_NOW(a_stall_holds_pc, clock, reset,
      s1_fire && ld_pend_ff && s1_func_ff == FUNC_EXEC,
      pc_in == pc_ff && !res.reg_write,
      "Instruction executed while a load was pending")
   `TCE_ASSERT_NEXT(a_load_sets_pending, clock, reset,
      s1_fire && res.mem_request == MEM_READ,
      ld_pend_ff && ld_dest_ff == $past(s1_d),
      "Load issue did not record the pending load")
   `TCE_ASSERT_NOW(a_no_write_clean, clock, reset, s1_fire && !res.reg_write,
      res.reg_index == '0 && res.reg_value == '0,
      "Register write fields not cleared without a write")
   `TCE_ASSERT_NOW(a_fwd_matches_mem, clock, reset,
      s1_valid_ff && lw_valid_ff && lw_idx_ff == s1_s && !(req_fire || s1_fire)
         && $past(s1_valid_ff && !s1_fire),
      rd_s_ff == lw_val_ff,
      "Forwarded value disagrees with register-file memory")

endmodule
